// ----- src/awd_pkg.sv -----
// ----------------------------------------------------------------------------
// awd_pkg
// Shared types, constants and calendar tables for the working-day adder.
// ----------------------------------------------------------------------------
package awd_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MASK_W  = 7;

    localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;
    localparam logic [MASK_W-1:0] MASK_ALL = 7'h7F;

    // Reciprocals for division by 100 and by 7; exact over the ranges used here
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int unsigned SHIFT_100 = 19;
    localparam logic [14:0] RECIP_7   = 15'd18725;
    localparam int unsigned SHIFT_7   = 17;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;
    localparam logic [4:0] LAST_DEC_DAY = 5'd31;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_DATE    = 2'd1,
        ST_OVERFLOW    = 2'd2,
        ST_NO_WORKDAY  = 2'd3
    } t_status;

    typedef struct packed {
        logic [4:0]        day;
        logic [3:0]        month;
        logic [YEAR_W-1:0] year;
        logic [6:0]        yr_mod100;
        logic [1:0]        cent_mod4;
        logic [2:0]        wday;
        t_status           status;
    } t_job;

    // Days in month; zero for a month code outside the calendar
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // (31 * mm) / 12 where mm counts months from March
    function automatic logic [4:0] month_offset(input logic [3:0] m);
        logic [4:0] off;
        case (m)
            4'd1:    off = 5'd28;
            4'd2:    off = 5'd31;
            4'd3:    off = 5'd2;
            4'd4:    off = 5'd5;
            4'd5:    off = 5'd7;
            4'd6:    off = 5'd10;
            4'd7:    off = 5'd12;
            4'd8:    off = 5'd15;
            4'd9:    off = 5'd18;
            4'd10:   off = 5'd20;
            4'd11:   off = 5'd23;
            4'd12:   off = 5'd25;
            default: off = 5'd0;
        endcase
        return off;
    endfunction

    function automatic logic is_leap(input logic [6:0] yr_mod100, input logic [1:0] cent_mod4);
        return ((yr_mod100[1:0] == 2'd0) && (yr_mod100 != 7'd0)) ||
               ((yr_mod100 == 7'd0) && (cent_mod4 == 2'd0));
    endfunction

endpackage

// ----- src/add_working_days_to_date.sv -----
// ----------------------------------------------------------------------------
// add_working_days_to_date
// Adds a count of working days to a Gregorian date, skipping weekend days
// marked in a programmable mask.
// ----------------------------------------------------------------------------
// Requests enter through a queue-style port: drive the start date and count
// and raise push; the request is taken on a clock edge where full is low.
// Results leave the same way: while empty is low the oldest result sits on
// o_end_* and o_status, and it is removed on an edge where pop is high.
// The weekend mask is written through i_cfg_data with i_cfg_valid; ready is
// always high. Write it only while no request is in flight.
// The front registers a request and then steps through its states in order:
// division by 100 for the year residues, date check and weekday sum, weekday
// modulo 7, and the push into the queue. It takes no new request until that
// push is done. The stepper works on one job at a time: it pops a job while
// idle, walks the calendar one day per cycle and places the finished date in
// the output register before it pops the next. A two-entry queue lets the
// front take the next request while the stepper works. If pop stays low the
// stepper holds its finished date and the queue fills, then full stays high.
// Reset clears all handshake state and sets the mask to Friday and Saturday.
// ----------------------------------------------------------------------------
module add_working_days_to_date #(
    parameter int unsigned DAY_COUNT_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [4:0]                    i_start_day,
    input  logic [3:0]                    i_start_month,
    input  logic [awd_pkg::YEAR_W-1:0]    i_start_year,
    input  logic [11:0]                   i_work_days,
    output logic                          empty,
    input  logic                          pop,
    output logic [4:0]                    o_end_day,
    output logic [3:0]                    o_end_month,
    output logic [awd_pkg::YEAR_W-1:0]    o_end_year,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [awd_pkg::MASK_W-1:0]    i_cfg_data
);
    import awd_pkg::*;

    localparam int unsigned QW = $bits(t_job) + DAY_COUNT_BITS;

    logic [MASK_W-1:0]         r_mask;
    logic                      q_push;
    logic                      q_full;
    logic                      q_pop;
    logic                      q_valid;
    t_job                      front_job;
    logic [DAY_COUNT_BITS-1:0] front_left;
    logic [QW-1:0]             q_out;
    t_job                      back_job;
    logic [DAY_COUNT_BITS-1:0] back_left;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= 7'd96;
        end else if (i_cfg_valid) begin
            r_mask <= i_cfg_data;
        end
    end

    awd_front #(
        .CNT_W (DAY_COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_day       (i_start_day),
        .i_month     (i_start_month),
        .i_year      (i_start_year),
        .i_work_days (i_work_days),
        .i_mask      (r_mask),
        .o_q_push    (q_push),
        .i_q_full    (q_full),
        .o_job       (front_job),
        .o_left      (front_left)
    );

    awd_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({front_job, front_left}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign back_job  = q_out[QW-1:DAY_COUNT_BITS];
    assign back_left = q_out[DAY_COUNT_BITS-1:0];

    awd_back #(
        .CNT_W (DAY_COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (back_job),
        .i_left      (back_left),
        .o_job_pop   (q_pop),
        .i_mask      (r_mask),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_day       (o_end_day),
        .o_month     (o_end_month),
        .o_year      (o_end_year),
        .o_status    (o_status)
    );

endmodule

// ----- src/awd_front.sv -----
// ----------------------------------------------------------------------------
// awd_front
// Takes a request, checks the start date and mask, and works out the start
// weekday and year residues before handing the job to the queue.
// ----------------------------------------------------------------------------
module awd_front #(
    parameter int unsigned CNT_W = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [4:0]                    i_day,
    input  logic [3:0]                    i_month,
    input  logic [awd_pkg::YEAR_W-1:0]    i_year,
    input  logic [11:0]                   i_work_days,
    input  logic [awd_pkg::MASK_W-1:0]    i_mask,
    output logic                          o_q_push,
    input  logic                          i_q_full,
    output awd_pkg::t_job                 o_job,
    output logic [CNT_W-1:0]              o_left
);
    import awd_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DIV,
        F_SUM,
        F_MOD,
        F_PUSH
    } t_fstate;

    t_fstate           r_state;
    logic [4:0]        r_d;
    logic [3:0]        r_m;
    logic [YEAR_W-1:0] r_y;
    logic [YEAR_W-1:0] r_yy;
    logic [CNT_W-1:0]  r_left;
    logic [7:0]        r_q100y;
    logic [7:0]        r_q100yy;
    logic [6:0]        r_r100;
    logic [14:0]       r_sum;
    logic [12:0]       r_q7;
    t_status           r_status;

    logic              jan_feb;
    logic [YEAR_W-1:0] n_yy;
    logic [26:0]       prod_y;
    logic [26:0]       prod_yy;
    logic [YEAR_W-1:0] rem100;
    logic [6:0]        n_r100;
    logic              leap;
    logic [4:0]        mlen;
    logic              date_ok;
    logic [14:0]       n_sum;
    logic [29:0]       prod_7;
    logic [14:0]       rem7;

    always_comb begin
        jan_feb = (r_m == MONTH_JAN) || (r_m == MONTH_FEB);
        n_yy    = r_y - YEAR_W'(jan_feb);
        prod_y  = 27'(r_y) * 27'(RECIP_100);
        prod_yy = 27'(n_yy) * 27'(RECIP_100);

        rem100  = r_y - YEAR_W'(YEAR_W'(r_q100y) * YEAR_W'(100));
        n_r100  = rem100[6:0];
        leap    = is_leap(n_r100, r_q100y[1:0]);
        mlen    = month_len(r_m, leap);
        date_ok = (r_m >= 4'd1) && (r_m <= MONTH_DEC) && (r_y >= YEAR_W'(1)) &&
                  (r_y <= MAX_YEAR) && (r_d >= 5'd1) && (r_d <= mlen);
        n_sum   = 15'(r_d) + 15'(r_yy) + 15'(r_yy >> 2) - 15'(r_q100yy)
                + 15'(r_q100yy >> 2) + 15'(month_offset(r_m));

        prod_7  = 30'(r_sum) * 30'(RECIP_7);
        rem7    = r_sum - 15'(15'(r_q7) * 15'(7));
    end

    assign o_full   = (r_state != F_IDLE);
    assign o_q_push = (r_state == F_PUSH) && !i_q_full;
    assign o_left   = r_left;

    always_comb begin
        o_job           = '0;
        o_job.day       = r_d;
        o_job.month     = r_m;
        o_job.year      = r_y;
        o_job.yr_mod100 = r_r100;
        o_job.cent_mod4 = r_q100y[1:0];
        o_job.wday      = rem7[2:0];
        o_job.status    = r_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_d     <= i_day;
                        r_m     <= i_month;
                        r_y     <= i_year;
                        r_left  <= CNT_W'(i_work_days);
                        r_state <= F_DIV;
                    end
                end
                F_DIV: begin
                    r_yy     <= n_yy;
                    r_q100y  <= prod_y[SHIFT_100 +: 8];
                    r_q100yy <= prod_yy[SHIFT_100 +: 8];
                    r_state  <= F_SUM;
                end
                F_SUM: begin
                    r_r100 <= n_r100;
                    r_sum  <= n_sum;
                    if (!date_ok) begin
                        r_status <= ST_BAD_DATE;
                    end else if (i_mask == MASK_ALL) begin
                        r_status <= ST_NO_WORKDAY;
                    end else begin
                        r_status <= ST_OK;
                    end
                    r_state <= F_MOD;
                end
                F_MOD: begin
                    r_q7    <= prod_7[SHIFT_7 +: 13];
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    // hold until the queue has room
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/awd_queue.sv -----
// ----------------------------------------------------------------------------
// awd_queue
// Two-entry queue that decouples the request front from the day stepper.
// ----------------------------------------------------------------------------
module awd_queue #(
    parameter int unsigned W = 48
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// ----- src/awd_back.sv -----
// ----------------------------------------------------------------------------
// awd_back
// Day stepper: walks the calendar one day per cycle, counts working days
// and places the finished date in the output register.
// ----------------------------------------------------------------------------
module awd_back #(
    parameter int unsigned CNT_W = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  awd_pkg::t_job                 i_job,
    input  logic [CNT_W-1:0]              i_left,
    output logic                          o_job_pop,
    input  logic [awd_pkg::MASK_W-1:0]    i_mask,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [4:0]                    o_day,
    output logic [3:0]                    o_month,
    output logic [awd_pkg::YEAR_W-1:0]    o_year,
    output logic [1:0]                    o_status
);
    import awd_pkg::*;

    logic              r_busy;
    logic [4:0]        r_d;
    logic [3:0]        r_m;
    logic [YEAR_W-1:0] r_y;
    logic [6:0]        r_r100;
    logic [1:0]        r_q4;
    logic [2:0]        r_wd;
    logic [CNT_W-1:0]  r_left;
    t_status           r_status;

    logic              r_out_valid;
    logic [4:0]        r_out_d;
    logic [3:0]        r_out_m;
    logic [YEAR_W-1:0] r_out_y;
    t_status           r_out_status;

    logic              at_end;
    logic              done;
    logic              out_free;
    logic              load_out;
    logic [4:0]        mlen;
    t_status           fin_status;

    always_comb begin
        at_end     = (r_d == LAST_DEC_DAY) && (r_m == MONTH_DEC) && (r_y == MAX_YEAR);
        done       = (r_status != ST_OK) || (r_left == '0) || at_end;
        fin_status = (r_status == ST_OK && r_left != '0) ? ST_OVERFLOW : r_status;
        out_free   = !r_out_valid || i_pop;
        load_out   = r_busy && done && out_free;
        mlen       = month_len(r_m, is_leap(r_r100, r_q4));
    end

    assign o_job_pop = !r_busy && i_job_valid;
    assign o_empty   = !r_out_valid;
    assign o_day     = r_out_d;
    assign o_month   = r_out_m;
    assign o_year    = r_out_y;
    assign o_status  = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end

            if (!r_busy) begin
                if (i_job_valid) begin
                    r_d      <= i_job.day;
                    r_m      <= i_job.month;
                    r_y      <= i_job.year;
                    r_r100   <= i_job.yr_mod100;
                    r_q4     <= i_job.cent_mod4;
                    r_wd     <= i_job.wday;
                    r_status <= i_job.status;
                    r_left   <= i_left;
                    r_busy   <= 1'b1;
                end
            end else if (done) begin
                // hold the finished date until the output register is free
                if (out_free) begin
                    r_out_d      <= r_d;
                    r_out_m      <= r_m;
                    r_out_y      <= r_y;
                    r_out_status <= fin_status;
                    r_busy       <= 1'b0;
                end
            end else begin
                if (r_d == mlen) begin
                    r_d <= 5'd1;
                    if (r_m == MONTH_DEC) begin
                        r_m <= MONTH_JAN;
                        r_y <= r_y + YEAR_W'(1);
                        if (r_r100 == 7'd99) begin
                            r_r100 <= 7'd0;
                            r_q4   <= r_q4 + 2'd1;
                        end else begin
                            r_r100 <= r_r100 + 7'd1;
                        end
                    end else begin
                        r_m <= r_m + 4'd1;
                    end
                end else begin
                    r_d <= r_d + 5'd1;
                end
                r_wd <= (r_wd == 3'd6) ? 3'd0 : r_wd + 3'd1;
                // count the step only when it starts on a working day
                if (!i_mask[r_wd]) begin
                    r_left <= r_left - CNT_W'(1);
                end
            end
        end
    end

endmodule
